FILE: design/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared constants and controller/datapath interface types for the
// trial-division prime test core.
// ----------------------------------------------------------------------------
package tdpt_pkg;

    // default candidate width
    localparam int VALUE_WIDTH_DEF = 32;

    // first trial divisor and its square (3 and 5 go through the same loop)
    localparam int FIRST_DIVISOR = 3;
    localparam int FIRST_SQUARE  = 9;

    // wheel steps and the square increments that go with them
    localparam int STEP_SHORT    = 2;
    localparam int STEP_LONG     = 4;
    localparam int SQ_ADD_SHORT  = 4;   // (d+2)^2 - d^2 = 4d + 4
    localparam int SQ_ADD_LONG   = 16;  // (d+4)^2 - d^2 = 8d + 16

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;       // capture a new candidate, reset divisor
        logic div_start;  // clear remainder, point at the top bit
        logic div_step;   // one restoring division bit
        logic advance;    // move to the next wheel divisor
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic neg;        // candidate is negative
        logic below_two;  // magnitude below two
        logic two;        // magnitude is exactly two
        logic even;       // low bit clear
        logic bound_over; // divisor squared exceeds the candidate
        logic div_last;   // current division bit is the last one
        logic rem_zero;   // remainder is zero
    } t_status;

endpackage

FILE: design/tdpt_dp.sv
// ----------------------------------------------------------------------------
// tdpt_dp
// Datapath: candidate register, wheel divisor with its running square,
// and a one-bit-per-cycle restoring remainder unit.
// ----------------------------------------------------------------------------
module tdpt_dp #(
    parameter int VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic [VALUE_WIDTH-1:0]  i_candidate,
    input  tdpt_pkg::t_cmd          i_cmd,
    output tdpt_pkg::t_status       o_status
);

    // magnitude width, divisor width, square width, bit index width
    localparam int VW = VALUE_WIDTH - 1;
    localparam int DW = (VALUE_WIDTH + 1) / 2 + 1;
    localparam int SW = 2 * DW;
    localparam int CW = $clog2(VW);

    logic [VW-1:0] r_value;
    logic          r_neg;
    logic [DW-1:0] r_div,  n_div;
    logic [SW-1:0] r_sq,   n_sq;
    logic          r_step_four, n_step_four;
    logic [DW-1:0] r_rem,  n_rem;
    logic [CW-1:0] r_bit;

    logic [DW:0]   w_shift;
    logic [DW:0]   w_diff;
    logic [SW-1:0] w_sq_inc;

    // restoring division bit: shift in the next candidate bit, subtract if it fits
    always_comb begin
        w_shift = {r_rem, r_value[r_bit]};
        w_diff  = w_shift - {1'b0, r_div};
        if (w_shift >= {1'b0, r_div}) begin
            n_rem = w_diff[DW-1:0];
        end else begin
            n_rem = w_shift[DW-1:0];
        end
    end

    // next wheel divisor and its square, no multiplier needed
    always_comb begin
        if (r_step_four) begin
            w_sq_inc = SW'({r_div, 3'b000}) + SW'(tdpt_pkg::SQ_ADD_LONG);
            n_div    = r_div + DW'(tdpt_pkg::STEP_LONG);
        end else begin
            w_sq_inc = SW'({r_div, 2'b00}) + SW'(tdpt_pkg::SQ_ADD_SHORT);
            n_div    = r_div + DW'(tdpt_pkg::STEP_SHORT);
        end
        n_sq        = r_sq + w_sq_inc;
        // steps go 3->5->7 by two, then alternate four and two
        n_step_four = !r_step_four && (r_div != DW'(tdpt_pkg::FIRST_DIVISOR));
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value     <= i_candidate[VW-1:0];
            r_neg       <= i_candidate[VALUE_WIDTH-1];
            r_div       <= DW'(tdpt_pkg::FIRST_DIVISOR);
            r_sq        <= SW'(tdpt_pkg::FIRST_SQUARE);
            r_step_four <= 1'b0;
        end else if (i_cmd.advance) begin
            r_div       <= n_div;
            r_sq        <= n_sq;
            r_step_four <= n_step_four;
        end
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_bit <= CW'(VW - 1);
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_bit <= r_bit - CW'(1);
        end
    end

    // status back to the controller
    always_comb begin
        o_status.neg        = r_neg;
        o_status.below_two  = (r_value < VW'(2));
        o_status.two        = (r_value == VW'(2));
        o_status.even       = !r_value[0];
        o_status.bound_over = (r_sq > SW'(r_value));
        o_status.div_last   = (r_bit == '0);
        o_status.rem_zero   = (r_rem == '0);
    end

endmodule

FILE: design/tdpt_ctrl.sv
// ----------------------------------------------------------------------------
// tdpt_ctrl
// Controller: sequences classification, the bound check, the bit-serial
// remainder and the divisor advance, and issues the result strobe.
// ----------------------------------------------------------------------------
module tdpt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  tdpt_pkg::t_status  i_status,
    output tdpt_pkg::t_cmd     o_cmd,
    output logic               o_valid,
    output logic               o_is_prime
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASSIFY,
        S_CHECK,
        S_DIVIDE,
        S_EVAL
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;
    logic   r_is_prime, n_is_prime;

    // next state, commands and result
    always_comb begin
        n_state    = r_state;
        n_valid    = 1'b0;
        n_is_prime = r_is_prime;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CLASSIFY;
                end
            end
            S_CLASSIFY: begin
                if (i_status.neg || i_status.below_two) begin
                    n_valid    = 1'b1;
                    n_is_prime = 1'b0;
                    n_state    = S_IDLE;
                end else if (i_status.two) begin
                    n_valid    = 1'b1;
                    n_is_prime = 1'b1;
                    n_state    = S_IDLE;
                end else if (i_status.even) begin
                    n_valid    = 1'b1;
                    n_is_prime = 1'b0;
                    n_state    = S_IDLE;
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.bound_over) begin
                    n_valid    = 1'b1;
                    n_is_prime = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIVIDE;
                end
            end
            S_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_status.rem_zero) begin
                    n_valid    = 1'b1;
                    n_is_prime = 1'b0;
                    n_state    = S_IDLE;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= 1'b0;
            r_is_prime <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_valid    <= n_valid;
            r_is_prime <= n_is_prime;
        end
    end

    assign busy       = (r_state != S_IDLE);
    assign o_valid    = r_valid;
    assign o_is_prime = r_is_prime;

endmodule

FILE: design/trial_division_prime_test_core.sv
// Negative, small or even candidates are settled by classification alone; any other
// candidate runs the bound check and a bit-serial remainder for each divisor tried.
// The remainder unit resolves one candidate bit per cycle while a division runs.
// One request at a time; the result strobe lasts one cycle and cannot be stalled.
// Synchronous active-low reset returns the controller to idle with no strobe.
// ----------------------------------------------------------------------------
// trial_division_prime_test_core
// Primality test by trial division over a 6k +- 1 wheel: controller and
// datapath joined by command and status structs.
// ----------------------------------------------------------------------------
module trial_division_prime_test_core #(
    parameter int VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [VALUE_WIDTH-1:0] i_candidate,
    output logic                   o_valid,
    output logic                   o_is_prime
);

    tdpt_pkg::t_cmd    w_cmd;
    tdpt_pkg::t_status w_status;

    // sequencing
    tdpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_valid    (o_valid),
        .o_is_prime (o_is_prime)
    );

    // arithmetic
    tdpt_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_candidate (i_candidate),
        .i_cmd       (w_cmd),
        .o_status    (w_status)
    );

endmodule
